// ===== rtl/matrix4_inverse_top_macros.svh =====
// assertion macros for the 4x4 matrix inverse block
// used by matrix4_inverse_top, no other dependencies
`ifndef MATRIX4_INVERSE_TOP_MACROS_SVH
`define MATRIX4_INVERSE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define M4INV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define M4INV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define M4INV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define M4INV_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/m4inv_pkg.sv =====
// shared widths, index helpers and divider result type for the 4x4 inverse
// no dependencies
package m4inv_pkg;

  localparam int DATA_W = 32;
  localparam int WIDE_W = 64;
  localparam int THR_W  = 17;
  localparam int POS_W  = 2;
  localparam int IDX_W  = 4;
  localparam logic [THR_W-1:0] THR_RESET = 17'd66;

  typedef struct packed {
    logic                     done;
    logic                     sat;
    logic signed [DATA_W-1:0] value;
  } div_res_t;

  // i-th of the three indexes left when x is removed
  function automatic logic [POS_W-1:0] skip(input logic [POS_W-1:0] i,
                                            input logic [POS_W-1:0] x);
    skip = (i >= x) ? i + 2'd1 : i;
  endfunction

  function automatic logic [IDX_W-1:0] mat_idx(input logic [POS_W-1:0] r,
                                               input logic [POS_W-1:0] c);
    mat_idx = {r, c};
  endfunction

  // row pairs of the minors over columns 0,1 in the determinant expansion
  function automatic logic [2*POS_W-1:0] det_rows_lo(input logic [2:0] t);
    case (t)
      3'd0:    det_rows_lo = {2'd0, 2'd1};
      3'd1:    det_rows_lo = {2'd0, 2'd2};
      3'd2:    det_rows_lo = {2'd0, 2'd3};
      3'd3:    det_rows_lo = {2'd1, 2'd2};
      3'd4:    det_rows_lo = {2'd1, 2'd3};
      default: det_rows_lo = {2'd2, 2'd3};
    endcase
  endfunction

  // row pairs of the minors over columns 2,3
  function automatic logic [2*POS_W-1:0] det_rows_hi(input logic [2:0] t);
    case (t)
      3'd0:    det_rows_hi = {2'd2, 2'd3};
      3'd1:    det_rows_hi = {2'd1, 2'd3};
      3'd2:    det_rows_hi = {2'd1, 2'd2};
      3'd3:    det_rows_hi = {2'd0, 2'd3};
      3'd4:    det_rows_hi = {2'd0, 2'd2};
      default: det_rows_hi = {2'd0, 2'd1};
    endcase
  endfunction

endpackage

// ===== rtl/m4inv_in_if.sv =====
// input channel: one matrix element per request
// depends on m4inv_pkg
interface m4inv_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [m4inv_pkg::DATA_W-1:0] element_value;
  logic                               first_element;
  modport source (output valid, element_value, first_element, input ready);
  modport sink   (input valid, element_value, first_element, output ready);
endinterface

// ===== rtl/m4inv_out_if.sv =====
// result channel: one inverse element per request
// depends on m4inv_pkg
interface m4inv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [m4inv_pkg::DATA_W-1:0] result_value;
  logic [m4inv_pkg::POS_W-1:0]         result_row;
  logic [m4inv_pkg::POS_W-1:0]         result_col;
  logic                               is_singular;
  logic                               overflowed;
  logic                               last_result;
  modport source (output valid, result_value, result_row, result_col, is_singular,
                  overflowed, last_result, input ready);
  modport sink   (input valid, result_value, result_row, result_col, is_singular,
                  overflowed, last_result, output ready);
endinterface

// ===== rtl/m4inv_cfg_if.sv =====
// configuration write channel for the singular threshold
// depends on m4inv_pkg
interface m4inv_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [m4inv_pkg::THR_W-1:0] singular_threshold;
  modport source (output valid, singular_threshold, input ready);
  modport sink   (input valid, singular_threshold, output ready);
endinterface

// ===== rtl/matrix4_inverse_top.sv =====
// 4x4 fixed-point matrix inverse by adjugate over determinant, shared multiplier
// depends on m4inv_pkg, the three channel interfaces, m4inv_div and the macro header
//
// Load sixteen signed Q16.16 elements row by row, one per request at one per
// cycle; first_element restarts at row 0 column 0. The block then stops taking
// elements and works through sixteen 3x3 cofactors and the determinant on one
// 32x32 multiplier, a step at a time. Each of the sixteen results then goes
// through a one-bit-per-cycle divider, which is skipped when the matrix is
// singular. Results come out row-major with row and column tags and last_result
// on the sixteenth; a determinant that is zero or whose magnitude is below
// singular_threshold gives sixteen zeros with is_singular set. The threshold
// write port is always ready; the user must write it only while no matrix is
// in flight, and the block itself does not enforce this.
`include "matrix4_inverse_top_macros.svh"

module matrix4_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  m4inv_in_if.sink           in_ch,
  m4inv_out_if.source        out_ch,
  m4inv_cfg_if.sink          cfg_ch
);

  localparam int DW = m4inv_pkg::DATA_W;
  localparam int WW = m4inv_pkg::WIDE_W;
  localparam logic signed [WW-1:0] RND = WW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [WW-1:0] MAX32 = 64'sd2147483647;
  localparam logic signed [WW-1:0] MIN32 = -64'sd2147483648;

  typedef enum logic [4:0] {
    ST_LOAD, ST_MN_A1, ST_MN_B1, ST_MN_C1, ST_MN_M1, ST_MN_R1, ST_MN_C2,
    ST_MN_M2, ST_MN_R2, ST_MN_D, ST_TE_A, ST_TE_M, ST_TE_R, ST_TE_ACC,
    ST_CHK, ST_EMIT, ST_DV_RD, ST_DV_GO, ST_DV_WAIT, ST_OUT
  } state_t;

  function automatic logic signed [WW-1:0] round_prod(input logic signed [WW-1:0] p);
    round_prod = (p + RND) >>> FRAC_BITS;
  endfunction

  state_t                   state_r;
  logic [m4inv_pkg::THR_W-1:0] thr_r;
  logic [m4inv_pkg::IDX_W-1:0] load_cnt_r;
  logic signed [DW-1:0]     mat_r [16];
  logic signed [WW-1:0]     cof_r [16];
  logic signed [DW-1:0]     mat_rd_r;
  logic signed [WW-1:0]     cof_rd_r;
  logic signed [DW-1:0]     opa_r;
  logic signed [DW-1:0]     opb_r;
  logic signed [DW-1:0]     mina_r;
  logic signed [WW-1:0]     prod_r;
  logic signed [WW-1:0]     pa_r;
  logic signed [WW-1:0]     pb_r;
  logic signed [WW-1:0]     acc_r;
  logic signed [WW-1:0]     det_r;
  logic [m4inv_pkg::IDX_W-1:0] k_r;
  logic [2:0]               t_r;
  logic                     det_ph_r;
  logic                     half_r;
  logic                     minsat_r;
  logic                     sing_r;
  logic                     out_valid_r;
  logic signed [DW-1:0]     out_value_r;
  logic                     out_ovf_r;

  logic                        in_fire;
  logic                        out_fire;
  logic [m4inv_pkg::IDX_W-1:0] load_idx;
  logic [1:0]                  cr;
  logic [1:0]                  cc;
  logic [1:0]                  mr1;
  logic [1:0]                  mr2;
  logic [1:0]                  mca;
  logic [1:0]                  mcb;
  logic [1:0]                  trow;
  logic [1:0]                  tcol;
  logic [3:0]                  rows_sel;
  logic [m4inv_pkg::IDX_W-1:0] rd_addr;
  logic signed [WW-1:0]        diff;
  logic signed [DW-1:0]        minor;
  logic                        minor_sat;
  logic                        acc_sub;
  logic signed [WW-1:0]        acc_sum;
  logic                        cof_we;
  logic signed [WW-1:0]        det_mag;
  logic                        div_start;
  m4inv_pkg::div_res_t         div_res;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign load_idx = in_ch.first_element ? '0 : load_cnt_r;
  assign cr       = k_r[3:2];
  assign cc       = k_r[1:0];

  always_comb begin
    rows_sel = half_r ? m4inv_pkg::det_rows_hi(t_r) : m4inv_pkg::det_rows_lo(t_r);
    if (det_ph_r) begin
      mr1 = rows_sel[3:2];
      mr2 = rows_sel[1:0];
      mca = half_r ? 2'd2 : 2'd0;
      mcb = half_r ? 2'd3 : 2'd1;
    end else begin
      mr1 = m4inv_pkg::skip(2'd1, cr);
      mr2 = m4inv_pkg::skip(2'd2, cr);
      mca = m4inv_pkg::skip((t_r == 3'd0) ? 2'd1 : 2'd0, cc);
      mcb = m4inv_pkg::skip((t_r == 3'd2) ? 2'd1 : 2'd2, cc);
    end
    trow = m4inv_pkg::skip(2'd0, cr);
    tcol = m4inv_pkg::skip(t_r[1:0], cc);
  end

  always_comb begin
    unique case (state_r)
      ST_MN_A1: rd_addr = m4inv_pkg::mat_idx(mr1, mca);
      ST_MN_B1: rd_addr = m4inv_pkg::mat_idx(mr2, mcb);
      ST_MN_M1: rd_addr = m4inv_pkg::mat_idx(mr2, mca);
      ST_MN_R1: rd_addr = m4inv_pkg::mat_idx(mr1, mcb);
      ST_MN_D:  rd_addr = m4inv_pkg::mat_idx(trow, tcol);
      default:  rd_addr = m4inv_pkg::mat_idx(mr1, mca);
    endcase
  end

  always_comb begin
    diff      = pa_r - pb_r;
    minor_sat = (diff > MAX32) || (diff < MIN32);
    if (diff > MAX32) begin
      minor = 32'sh7fff_ffff;
    end else if (diff < MIN32) begin
      minor = 32'sh8000_0000;
    end else begin
      minor = diff[DW-1:0];
    end
    acc_sub = det_ph_r ? (t_r == 3'd1 || t_r == 3'd4) : (t_r == 3'd1);
    acc_sum = acc_sub ? acc_r - pa_r : acc_r + pa_r;
    cof_we  = (state_r == ST_TE_ACC) && !det_ph_r && (t_r == 3'd2);
    det_mag = det_r[WW-1] ? -det_r : det_r;
  end

  // element and cofactor stores
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mat_r[load_idx] <= in_ch.element_value;
    end
    if (cof_we) begin
      cof_r[{cc, cr}] <= (cr[0] ^ cc[0]) ? -acc_sum : acc_sum;
    end
    mat_rd_r <= mat_r[rd_addr];
    cof_rd_r <= cof_r[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= m4inv_pkg::THR_RESET;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.singular_threshold;
    end
  end

  assign div_start = (state_r == ST_DV_GO);

  m4inv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (cof_rd_r),
    .den   (det_r),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            load_cnt_r <= load_idx + 1'b1;
            if (load_idx == 4'd15) begin
              k_r      <= '0;
              t_r      <= '0;
              det_ph_r <= 1'b0;
              half_r   <= 1'b0;
              acc_r    <= '0;
              minsat_r <= 1'b0;
              state_r  <= ST_MN_A1;
            end
          end
        end
        ST_MN_A1: state_r <= ST_MN_B1;
        ST_MN_B1: begin
          opa_r   <= mat_rd_r;
          state_r <= ST_MN_C1;
        end
        ST_MN_C1: begin
          opb_r   <= mat_rd_r;
          state_r <= ST_MN_M1;
        end
        ST_MN_M1: begin
          prod_r  <= opa_r * opb_r;
          state_r <= ST_MN_R1;
        end
        ST_MN_R1: begin
          pa_r    <= round_prod(prod_r);
          opa_r   <= mat_rd_r;
          state_r <= ST_MN_C2;
        end
        ST_MN_C2: begin
          opb_r   <= mat_rd_r;
          state_r <= ST_MN_M2;
        end
        ST_MN_M2: begin
          prod_r  <= opa_r * opb_r;
          state_r <= ST_MN_R2;
        end
        ST_MN_R2: begin
          pb_r    <= round_prod(prod_r);
          state_r <= ST_MN_D;
        end
        ST_MN_D: begin
          minsat_r <= minsat_r | minor_sat;
          if (!det_ph_r) begin
            opb_r   <= minor;
            state_r <= ST_TE_A;
          end else if (!half_r) begin
            mina_r  <= minor;
            half_r  <= 1'b1;
            state_r <= ST_MN_A1;
          end else begin
            opa_r   <= mina_r;
            opb_r   <= minor;
            state_r <= ST_TE_M;
          end
        end
        ST_TE_A: begin
          opa_r   <= mat_rd_r;
          state_r <= ST_TE_M;
        end
        ST_TE_M: begin
          prod_r  <= opa_r * opb_r;
          state_r <= ST_TE_R;
        end
        ST_TE_R: begin
          pa_r    <= round_prod(prod_r);
          state_r <= ST_TE_ACC;
        end
        ST_TE_ACC: begin
          half_r <= 1'b0;
          if (!det_ph_r) begin
            if (t_r == 3'd2) begin
              acc_r <= '0;
              t_r   <= '0;
              k_r   <= k_r + 1'b1;
              if (k_r == 4'd15) begin
                det_ph_r <= 1'b1;
              end
            end else begin
              acc_r <= acc_sum;
              t_r   <= t_r + 1'b1;
            end
            state_r <= ST_MN_A1;
          end else if (t_r == 3'd5) begin
            det_r   <= acc_sum;
            state_r <= ST_CHK;
          end else begin
            acc_r   <= acc_sum;
            t_r     <= t_r + 1'b1;
            state_r <= ST_MN_A1;
          end
        end
        ST_CHK: begin
          sing_r  <= (det_mag == '0) || (det_mag < WW'(thr_r));
          k_r     <= '0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sing_r) begin
            out_value_r <= '0;
            out_ovf_r   <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end else begin
            state_r <= ST_DV_RD;
          end
        end
        ST_DV_RD: state_r <= ST_DV_GO;
        ST_DV_GO: state_r <= ST_DV_WAIT;
        ST_DV_WAIT: begin
          if (div_res.done) begin
            out_value_r <= div_res.value;
            out_ovf_r   <= div_res.sat | minsat_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 1'b1;
            state_r     <= (k_r == 4'd15) ? ST_LOAD : ST_EMIT;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.result_row   = k_r[3:2];
  assign out_ch.result_col   = k_r[1:0];
  assign out_ch.is_singular  = sing_r;
  assign out_ch.overflowed   = out_ovf_r;
  assign out_ch.last_result  = (k_r == 4'd15);

  `M4INV_ASSERT_IMP(a_no_load_while_out, clk, rst_n, in_ch.ready, !out_ch.valid)
  `M4INV_ASSERT_NXT(a_last_back_to_load, clk, rst_n, out_fire && out_ch.last_result, in_ch.ready)
  `M4INV_ASSERT_IMP(a_singular_zero, clk, rst_n, out_ch.valid && out_ch.is_singular, out_ch.result_value == '0 && !out_ch.overflowed)
  `M4INV_ASSERT_NXT(a_full_load_busy, clk, rst_n, in_fire && load_idx == 4'd15, !in_ch.ready)

endmodule

// ===== rtl/m4inv_div.sv =====
// bit-serial signed fixed-point divider: round(num * 2^FRAC_BITS / den), saturated
// depends on m4inv_pkg
module m4inv_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [m4inv_pkg::WIDE_W-1:0] num,
  input  logic signed [m4inv_pkg::WIDE_W-1:0] den,
  output m4inv_pkg::div_res_t                 res
);

  localparam int W     = m4inv_pkg::WIDE_W;
  localparam int STEPS = W + FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS);
  localparam int Q_W   = m4inv_pkg::DATA_W + 1;

  typedef enum logic [1:0] {DS_IDLE, DS_RUN, DS_FIN} dstate_t;

  dstate_t             state_r;
  logic [W-1:0]        dvd_r;
  logic [W-1:0]        rem_r;
  logic [W-1:0]        den_r;
  logic [Q_W-1:0]      q_r;
  logic                big_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  m4inv_pkg::div_res_t res_r;

  logic [W:0]   shifted;
  logic         fits;
  logic [W:0]   rem_dbl;
  logic [Q_W:0] q_fin;
  logic         sat_pos;
  logic         sat_neg;

  always_comb begin
    shifted = {rem_r, dvd_r[W-1]};
    fits    = shifted >= {1'b0, den_r};
    rem_dbl = {rem_r, 1'b0};
    q_fin   = {1'b0, q_r} + {{Q_W{1'b0}}, (rem_dbl >= {1'b0, den_r})};
    sat_pos = !neg_r && (big_r || q_fin > (Q_W+1)'(32'h7fff_ffff));
    sat_neg = neg_r && (big_r || q_fin > (Q_W+1)'(33'h1_0000_0000 >> 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= DS_IDLE;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      unique case (state_r)
        DS_IDLE: begin
          if (start) begin
            dvd_r   <= num[W-1] ? W'(-num) : num;
            den_r   <= den[W-1] ? W'(-den) : den;
            neg_r   <= num[W-1] ^ den[W-1];
            rem_r   <= '0;
            q_r     <= '0;
            big_r   <= 1'b0;
            cnt_r   <= '0;
            state_r <= DS_RUN;
          end
        end
        DS_RUN: begin
          rem_r <= fits ? W'(shifted - {1'b0, den_r}) : shifted[W-1:0];
          dvd_r <= {dvd_r[W-2:0], 1'b0};
          q_r   <= {q_r[Q_W-2:0], fits};
          big_r <= big_r | q_r[Q_W-1];
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(STEPS-1)) begin
            state_r <= DS_FIN;
          end
        end
        DS_FIN: begin
          res_r.done <= 1'b1;
          res_r.sat  <= sat_pos | sat_neg;
          if (sat_pos) begin
            res_r.value <= 32'sh7fff_ffff;
          end else if (sat_neg) begin
            res_r.value <= 32'sh8000_0000;
          end else if (neg_r) begin
            res_r.value <= -$signed(q_fin[m4inv_pkg::DATA_W-1:0]);
          end else begin
            res_r.value <= $signed(q_fin[m4inv_pkg::DATA_W-1:0]);
          end
          state_r <= DS_IDLE;
        end
        default: state_r <= DS_IDLE;
      endcase
    end
  end

  assign res = res_r;

endmodule
